>>> src/avcc_pkg.sv
// avcc_pkg: shared types and codes for the avcc to annex b converter
// used by avcc_parse, avcc_emit and the top level; no dependencies
package avcc_pkg;

  // result status codes
  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_END_OK    = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_TRUNC_REC = 3'd3;
  localparam logic [2:0] ST_TRUNC_PAY = 3'd4;

  // input word kinds
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // fixed widths
  localparam int ACC_W = 32;

  // parser phases, one-hot
  typedef enum logic [13:0] {
    PH_REC_FIRST = 14'b00000000000001,
    PH_REC_HDR   = 14'b00000000000010,
    PH_SPS_HI    = 14'b00000000000100,
    PH_SPS_LO    = 14'b00000000001000,
    PH_SPS_BODY  = 14'b00000000010000,
    PH_PPS_COUNT = 14'b00000000100000,
    PH_PPS_HI    = 14'b00000001000000,
    PH_PPS_LO    = 14'b00000010000000,
    PH_PPS_BODY  = 14'b00000100000000,
    PH_REC_DONE  = 14'b00001000000000,
    PH_REC_PASS  = 14'b00010000000000,
    PH_REC_BAD   = 14'b00100000000000,
    PH_PAY_LEN   = 14'b01000000000000,
    PH_PAY_BODY  = 14'b10000000000000
  } phase_t;

  // everything one input word produces, in output order:
  // start code, then data byte, then end status
  typedef struct packed {
    logic       start;
    logic       data_en;
    logic [7:0] data;
    logic [2:0] end_st;
  } bundle_t;

endpackage

>>> src/avcc_parse.sv
// avcc_parse: parser state registers and the per-word next-state logic
// depends on avcc_pkg; produces one bundle_t per accepted word
module avcc_parse
  import avcc_pkg::*;
#(
  parameter int MAX_NAL_LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_accept,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       last,
  output bundle_t    bundle
);

  localparam int NB = MAX_NAL_LENGTH_BITS;
  localparam logic [ACC_W-1:0] CAP = ACC_W'((64'd1 << NB) - 64'd1);

  phase_t            phase, phase_next;
  logic              avcc_mode, avcc_mode_next;
  logic [2:0]        lfs, lfs_next;
  logic [2:0]        hidx, hidx_next;
  logic [7:0]        sets, sets_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [NB-1:0]     rem, rem_next;
  logic [2:0]        seen, seen_next;

  logic [15:0]       rec_len;
  logic [7:0]        sets_dec;
  logic              pps;
  logic              fin;
  logic [ACC_W-1:0]  acc_sh;
  logic [ACC_W-1:0]  sat_len;
  logic [2:0]        seen_inc;
  logic              ok;

  always_comb begin
    phase_next     = phase;
    avcc_mode_next = avcc_mode;
    lfs_next       = lfs;
    hidx_next      = hidx;
    sets_next      = sets;
    acc_next       = acc;
    rem_next       = rem;
    seen_next      = seen;
    bundle         = '0;
    rec_len        = {acc[7:0], data_byte};
    sets_dec       = sets - 8'd1;
    pps            = 1'b0;
    fin            = 1'b0;
    acc_sh         = '0;
    sat_len        = '0;
    seen_inc       = '0;
    ok             = 1'b0;

    if (action == KIND_RECORD) begin
      // a record word abandons an unfinished payload buffer
      if (phase == PH_PAY_LEN || phase == PH_PAY_BODY) begin
        phase_next = PH_REC_FIRST;
      end
      case (phase_next)
        PH_REC_FIRST: begin
          if (data_byte == 8'd0) begin
            avcc_mode_next = 1'b0;
            phase_next     = PH_REC_PASS;
          end else if (data_byte == 8'd1) begin
            avcc_mode_next = 1'b1;
            hidx_next      = 3'd1;
            phase_next     = PH_REC_HDR;
          end else begin
            phase_next = PH_REC_BAD;
          end
        end
        PH_REC_HDR: begin
          if (hidx == 3'd4) begin
            lfs_next = {1'b0, data_byte[1:0]} + 3'd1;
          end
          if (hidx >= 3'd5) begin
            sets_next  = {3'd0, data_byte[4:0]};
            phase_next = (data_byte[4:0] != 5'd0) ? PH_SPS_HI : PH_PPS_COUNT;
          end else begin
            hidx_next = hidx + 3'd1;
          end
        end
        PH_SPS_HI: begin
          acc_next   = ACC_W'(data_byte);
          phase_next = PH_SPS_LO;
        end
        PH_PPS_HI: begin
          acc_next   = ACC_W'(data_byte);
          phase_next = PH_PPS_LO;
        end
        PH_SPS_LO, PH_PPS_LO: begin
          pps          = (phase_next == PH_PPS_LO);
          rem_next     = NB'(rec_len);
          acc_next     = ACC_W'(rec_len);
          bundle.start = 1'b1;
          if (rec_len != 16'd0) begin
            phase_next = pps ? PH_PPS_BODY : PH_SPS_BODY;
          end else begin
            fin = 1'b1;
          end
        end
        PH_SPS_BODY, PH_PPS_BODY: begin
          pps            = (phase_next == PH_PPS_BODY);
          bundle.data_en = 1'b1;
          bundle.data    = data_byte;
          rem_next       = rem - NB'(1);
          if (rem_next == '0) begin
            fin = 1'b1;
          end
        end
        PH_PPS_COUNT: begin
          sets_next  = data_byte;
          phase_next = (data_byte != 8'd0) ? PH_PPS_HI : PH_REC_DONE;
        end
        default: begin
        end
      endcase

      // parameter set finished: next set or next section
      if (fin) begin
        sets_next = sets_dec;
        if (sets_dec != 8'd0) begin
          phase_next = pps ? PH_PPS_HI : PH_SPS_HI;
        end else begin
          phase_next = pps ? PH_REC_DONE : PH_PPS_COUNT;
        end
      end

      if (last) begin
        if (phase_next == PH_REC_DONE || phase_next == PH_REC_PASS) begin
          bundle.end_st = ST_END_OK;
        end else if (phase_next == PH_REC_BAD) begin
          bundle.end_st = ST_BAD_VER;
        end else begin
          bundle.end_st = ST_TRUNC_REC;
        end
        phase_next = PH_REC_FIRST;
      end
    end else begin
      // a payload word abandons an unfinished record
      if (phase != PH_PAY_LEN && phase != PH_PAY_BODY) begin
        phase_next = PH_PAY_LEN;
        seen_next  = 3'd0;
        acc_next   = '0;
      end

      if (!avcc_mode) begin
        bundle.data_en = 1'b1;
        bundle.data    = data_byte;
      end else if (phase_next == PH_PAY_LEN) begin
        acc_sh    = {acc_next[ACC_W-9:0], data_byte};
        seen_inc  = seen_next + 3'd1;
        acc_next  = acc_sh;
        seen_next = seen_inc;
        if (seen_inc >= lfs) begin
          sat_len      = (acc_sh > CAP) ? CAP : acc_sh;
          bundle.start = 1'b1;
          rem_next     = sat_len[NB-1:0];
          acc_next     = '0;
          seen_next    = 3'd0;
          phase_next   = (sat_len != '0) ? PH_PAY_BODY : PH_PAY_LEN;
        end
      end else begin
        bundle.data_en = 1'b1;
        bundle.data    = data_byte;
        rem_next       = rem - NB'(1);
        if (rem_next == '0) begin
          phase_next = PH_PAY_LEN;
        end
      end

      if (last) begin
        ok            = !avcc_mode || (phase_next == PH_PAY_LEN && seen_next == 3'd0);
        bundle.end_st = ok ? ST_END_OK : ST_TRUNC_PAY;
        phase_next    = PH_PAY_LEN;
        seen_next     = 3'd0;
        acc_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_REC_FIRST;
      avcc_mode <= 1'b0;
      lfs       <= 3'd4;
      hidx      <= 3'd0;
      sets      <= 8'd0;
      acc       <= '0;
      rem       <= '0;
      seen      <= 3'd0;
    end else if (in_accept) begin
      phase     <= phase_next;
      avcc_mode <= avcc_mode_next;
      lfs       <= lfs_next;
      hidx      <= hidx_next;
      sets      <= sets_next;
      acc       <= acc_next;
      rem       <= rem_next;
      seen      <= seen_next;
    end
  end

  a_lfs_range: assert property (@(posedge clk) disable iff (rst)
    lfs != 3'd0 && lfs <= 3'd4)
    else $error("length field size out of range");

  a_hidx_range: assert property (@(posedge clk) disable iff (rst)
    hidx <= 3'd5)
    else $error("header index out of range");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY_BODY || phase == PH_SPS_BODY || phase == PH_PPS_BODY) |-> rem != '0)
    else $error("body phase with no bytes remaining");

endmodule

>>> src/avcc_emit.sv
// avcc_emit: result register holding one bundle and serializing it to words
// depends on avcc_pkg; start code, data byte and end status leave in that order
module avcc_emit
  import avcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    bundle,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] m_tdata,
  output logic [2:0] m_tuser,
  output logic       m_tlast,
  output logic       m_tvalid,
  input  logic       m_tready
);

  logic [2:0] start_cnt, start_cnt_next;
  logic       data_pend, data_pend_next;
  logic       end_pend, end_pend_next;
  logic [7:0] data, data_next;
  logic [2:0] end_st, end_st_next;
  logic [2:0] words_left;
  logic       take;

  assign words_left = start_cnt + {2'd0, data_pend} + {2'd0, end_pend};
  assign m_tvalid   = (words_left != 3'd0);
  assign m_tlast    = (words_left == 3'd1);
  assign take       = m_tvalid && m_tready;
  assign in_ready   = !m_tvalid || (take && m_tlast);

  always_comb begin
    m_tdata = 8'd0;
    m_tuser = ST_DATA;
    if (start_cnt != 3'd0) begin
      m_tdata = (start_cnt == 3'd1) ? 8'd1 : 8'd0;
    end else if (data_pend) begin
      m_tdata = data;
    end else begin
      m_tuser = end_st;
    end
  end

  always_comb begin
    start_cnt_next = start_cnt;
    data_pend_next = data_pend;
    end_pend_next  = end_pend;
    data_next      = data;
    end_st_next    = end_st;
    if (take) begin
      if (start_cnt != 3'd0) begin
        start_cnt_next = start_cnt - 3'd1;
      end else if (data_pend) begin
        data_pend_next = 1'b0;
      end else begin
        end_pend_next = 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      start_cnt_next = bundle.start ? 3'd4 : 3'd0;
      data_pend_next = bundle.data_en;
      end_pend_next  = (bundle.end_st != ST_DATA);
      data_next      = bundle.data;
      end_st_next    = bundle.end_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cnt <= 3'd0;
      data_pend <= 1'b0;
      end_pend  <= 1'b0;
    end else begin
      start_cnt <= start_cnt_next;
      data_pend <= data_pend_next;
      end_pend  <= end_pend_next;
    end
    data   <= data_next;
    end_st <= end_st_next;
  end

  a_start_range: assert property (@(posedge clk) disable iff (rst)
    start_cnt <= 3'd4)
    else $error("start code counter out of range");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_DATA) |-> m_tlast)
    else $error("end status not the final word of its bundle");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("bundle dropped before its final word");

endmodule

>>> src/avcc_to_annexb_converter_unit.sv
// avcc_to_annexb_converter_unit: top level of the avcc to annex b converter
// depends on avcc_pkg, avcc_parse and avcc_emit
//
//  channel | dir | tdata          | tuser               | tlast
//  --------+-----+----------------+---------------------+---------------------
//  s_*     | in  | [7:0] data     | [0] action          | last byte of buffer
//          |     |                | 0 record, 1 payload |
//  m_*     | out | [7:0] out byte | [2:0] status        | last word of a bundle
//
// one input word per cycle when it produces at most one output word and m_tready stays high
// a word that opens a nal produces 4 start code words, so s_tready drops
// while the output serializer drains that bundle
// the state update happens in the accept cycle, results sit in one bundle register
// rst is synchronous active high and needs no clearing pass
// m_tready low holds the bundle and, once it is not draining, holds s_tready low
module avcc_to_annexb_converter_unit
  import avcc_pkg::*;
#(
  parameter int MAX_NAL_LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] action
  input  logic       s_tlast,
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [2:0] status
  output logic       m_tlast
);

  bundle_t bundle;
  logic    in_accept;

  // a word is taken whenever the result register is empty or draining its last word
  assign in_accept = s_tvalid && s_tready;

  // parser: state registers and per-word next state
  avcc_parse #(
    .MAX_NAL_LENGTH_BITS(MAX_NAL_LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .action    (s_tuser),
    .data_byte (s_tdata),
    .last      (s_tlast),
    .bundle    (bundle)
  );

  // result register and word serializer
  avcc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

endmodule

>>> bench/tb_avcc_to_annexb_converter_unit.sv
// tb_avcc_to_annexb_converter_unit: self-checking bench for the avcc to annex b converter
// depends on avcc_pkg and avcc_to_annexb_converter_unit; a directed table, then random
// record and payload buffers, each output word compared with a table entry or an in-bench conversion model
module tb_avcc_to_annexb_converter_unit;
  import avcc_pkg::*;

  localparam int NAL_LEN_BITS = 32;
  localparam int RAND_ITEMS   = 125;
  localparam int HOLD_AT      = 50;     // random word count that triggers the long sink hold
  localparam int LONG_HOLD    = 300;    // cycles the sink holds m_tready low once
  localparam int DRAIN_CYCLES = 20;     // start code burst plus bundle register, with margin
  // longest correct quiet stretch is the long hold plus a sender gap, so allow 5x that
  localparam int QUIET_LIMIT  = 5 * (LONG_HOLD + 10);
  localparam int MAX_REPORTS  = 40;
  localparam int N_DIR        = 25;

  // first record byte values
  localparam logic [7:0] VER_ANNEXB = 8'h00;
  localparam logic [7:0] VER_AVCC   = 8'h01;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] val;
    logic [2:0] st;
    logic       run_end;
  } out_word_t;

  // directed row: a typed row carries its single expected word, run_end implied
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] t_val;
    logic [2:0] t_st;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // right after reset: pass-through, payload copied as is
    '{KIND_PAYLOAD, 8'h00, 1'b0, 1'b1, 8'h00, ST_DATA},
    '{KIND_PAYLOAD, 8'hFF, 1'b1, 1'b0, 8'h00, ST_DATA},
    // record with a bad first byte, mode stays pass-through
    '{KIND_RECORD,  8'h07, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h55, 1'b1, 1'b1, 8'h00, ST_BAD_VER},
    // pass-through record
    '{KIND_RECORD,  8'h00, 1'b1, 1'b1, 8'h00, ST_END_OK},
    // avcc record: header, 1-byte lengths, sps count with high bits set
    '{KIND_RECORD,  8'h01, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'hFF, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h64, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h00, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'hFC, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'hE1, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h00, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h02, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h67, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h42, 1'b0, 1'b0, 8'h00, ST_DATA},
    // no pps, then a trailing byte that the parser ignores
    '{KIND_RECORD,  8'h00, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'hAB, 1'b1, 1'b1, 8'h00, ST_END_OK},
    // payload: zero-length nal, a 2-byte nal, then a nal cut by the buffer end
    '{KIND_PAYLOAD, 8'h00, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_PAYLOAD, 8'h02, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_PAYLOAD, 8'h80, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_PAYLOAD, 8'h7F, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_PAYLOAD, 8'h03, 1'b1, 1'b0, 8'h00, ST_DATA},
    // payload abandoned by a record word, then a record cut short
    '{KIND_PAYLOAD, 8'h01, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h01, 1'b0, 1'b0, 8'h00, ST_DATA},
    '{KIND_RECORD,  8'h00, 1'b1, 1'b1, 8'h00, ST_TRUNC_REC}
  };

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] data_byte
  logic       s_tuser;   // [0] action
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic [2:0] m_tuser;   // [2:0] status
  logic       m_tlast;

  avcc_to_annexb_converter_unit #(
    .MAX_NAL_LENGTH_BITS(NAL_LEN_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // conversion model state
  logic        avcc_on;
  logic [2:0]  nal_len_bytes;
  phase_t      parse_ph;
  logic [2:0]  hdr_pos;
  logic [7:0]  sets_left;
  logic [31:0] len_acc;
  logic [31:0] body_left;
  logic [2:0]  len_seen;

  out_word_t annexb_due [$];   // annex b words still to come, oldest first
  in_word_t  burst [$];        // random buffer being built
  bit        logging;
  int        made;

  int  words_in, words_out, ends_seen, ends_flagged, bad_cnt, quiet;
  int  calm_in, calm_out, rand_sent;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // conversion model
  // ---------------------------------------------------------------------------

  function automatic void put_word(input logic [7:0] v, input logic [2:0] st);
    out_word_t w;
    w = '{v, st, 1'b0};
    if (logging) annexb_due = {annexb_due, w};
    made++;
  endfunction

  function automatic void put_start_code();
    put_word(8'h00, ST_DATA);
    put_word(8'h00, ST_DATA);
    put_word(8'h00, ST_DATA);
    put_word(8'h01, ST_DATA);
  endfunction

  // one parameter set finished: next set of the same kind, or move on
  function automatic void set_finished(input logic pps);
    sets_left = sets_left - 8'd1;
    if (sets_left != 8'd0) begin
      parse_ph = pps ? PH_PPS_HI : PH_SPS_HI;
    end else begin
      parse_ph = pps ? PH_REC_DONE : PH_PPS_COUNT;
    end
  endfunction

  // advance the model by one input word; logit = 0 only advances the state
  function automatic void convert_word(input in_word_t w, input bit logit);
    logic        pps;
    logic        ok;
    logic [32:0] cap;
    logic [2:0]  st;
    out_word_t   tail;
    logging = logit;
    made = 0;
    cap = (33'd1 << NAL_LEN_BITS) - 33'd1;
    if (w.kind == KIND_RECORD) begin
      // a record word abandons any unfinished payload buffer
      if (parse_ph == PH_PAY_LEN || parse_ph == PH_PAY_BODY) parse_ph = PH_REC_FIRST;
      pps = (parse_ph == PH_PPS_HI) || (parse_ph == PH_PPS_LO) || (parse_ph == PH_PPS_BODY);
      case (parse_ph)
        PH_REC_FIRST: begin
          if (w.data == VER_ANNEXB) begin
            avcc_on = 1'b0;
            parse_ph = PH_REC_PASS;
          end else if (w.data == VER_AVCC) begin
            avcc_on = 1'b1;
            hdr_pos = 3'd1;
            parse_ph = PH_REC_HDR;
          end else begin
            parse_ph = PH_REC_BAD;
          end
        end
        PH_REC_HDR: begin
          if (hdr_pos == 3'd4) nal_len_bytes = {1'b0, w.data[1:0]} + 3'd1;
          if (hdr_pos >= 3'd5) begin
            sets_left = {3'b000, w.data[4:0]};
            parse_ph = (sets_left != 8'd0) ? PH_SPS_HI : PH_PPS_COUNT;
          end else begin
            hdr_pos = hdr_pos + 3'd1;
          end
        end
        PH_SPS_HI, PH_PPS_HI: begin
          len_acc = {24'd0, w.data};
          parse_ph = pps ? PH_PPS_LO : PH_SPS_LO;
        end
        PH_SPS_LO, PH_PPS_LO: begin
          body_left = {16'd0, len_acc[7:0], w.data};
          len_acc = body_left;
          put_start_code();
          if (body_left != 32'd0) begin
            parse_ph = pps ? PH_PPS_BODY : PH_SPS_BODY;
          end else begin
            set_finished(pps);
          end
        end
        PH_SPS_BODY, PH_PPS_BODY: begin
          put_word(w.data, ST_DATA);
          body_left = body_left - 32'd1;
          if (body_left == 32'd0) set_finished(pps);
        end
        PH_PPS_COUNT: begin
          sets_left = w.data;
          parse_ph = (sets_left != 8'd0) ? PH_PPS_HI : PH_REC_DONE;
        end
        default: ;
      endcase
      if (w.last) begin
        if (parse_ph == PH_REC_DONE || parse_ph == PH_REC_PASS) begin
          st = ST_END_OK;
        end else if (parse_ph == PH_REC_BAD) begin
          st = ST_BAD_VER;
        end else begin
          st = ST_TRUNC_REC;
        end
        put_word(8'h00, st);
        parse_ph = PH_REC_FIRST;
      end
    end else begin
      // a payload word during an unfinished record starts a fresh payload buffer
      if (parse_ph != PH_PAY_LEN && parse_ph != PH_PAY_BODY) begin
        parse_ph = PH_PAY_LEN;
        len_seen = 3'd0;
        len_acc = 32'd0;
      end
      if (!avcc_on) begin
        put_word(w.data, ST_DATA);
      end else if (parse_ph == PH_PAY_LEN) begin
        len_acc = {len_acc[23:0], w.data};
        len_seen = len_seen + 3'd1;
        if (len_seen >= nal_len_bytes) begin
          put_start_code();
          body_left = ({1'b0, len_acc} > cap) ? cap[31:0] : len_acc;
          len_acc = 32'd0;
          len_seen = 3'd0;
          parse_ph = (body_left != 32'd0) ? PH_PAY_BODY : PH_PAY_LEN;
        end
      end else begin
        put_word(w.data, ST_DATA);
        body_left = body_left - 32'd1;
        if (body_left == 32'd0) parse_ph = PH_PAY_LEN;
      end
      if (w.last) begin
        ok = !avcc_on || (parse_ph == PH_PAY_LEN && len_seen == 3'd0);
        put_word(8'h00, ok ? ST_END_OK : ST_TRUNC_PAY);
        parse_ph = PH_PAY_LEN;
        len_seen = 3'd0;
        len_acc = 32'd0;
      end
    end
    // the last word caused by this input carries run_end
    if (logit && made > 0) begin
      tail = annexb_due[annexb_due.size() - 1];
      tail.run_end = 1'b1;
      annexb_due[annexb_due.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // random per word wait, with occasional stretches of back-to-back words
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_word(input logic kind, input logic [7:0] data);
    in_word_t w;
    w = '{kind, data, 1'b0};
    burst = {burst, w};
  endfunction

  // sometimes cut the buffer short, mark its end, and rarely leave the end unmarked
  function automatic void close_burst();
    in_word_t w;
    int       cut;
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, burst.size());
      while (burst.size() > cut) void'(burst.pop_back());
    end
    w = burst[burst.size() - 1];
    w.last = ($urandom_range(0, 11) != 0);
    burst[burst.size() - 1] = w;
  endfunction

  // parameter set: 16-bit length then body; a broken set gets a wild high length byte
  task automatic add_set(input logic broken);
    int len;
    len = $urandom_range(0, 4);
    add_word(KIND_RECORD, broken ? rand_byte() : 8'h00);
    add_word(KIND_RECORD, 8'(len));
    repeat (len) add_word(KIND_RECORD, rand_byte());
  endtask

  task automatic make_record();
    int   pick;
    int   nsets;
    logic broken;
    burst.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      add_word(KIND_RECORD, VER_ANNEXB);
      repeat ($urandom_range(0, 3)) add_word(KIND_RECORD, rand_byte());
    end else if (pick == 1) begin
      add_word(KIND_RECORD, 8'($urandom_range(2, 255)));
      repeat ($urandom_range(0, 3)) add_word(KIND_RECORD, rand_byte());
    end else begin
      broken = (pick == 2);
      add_word(KIND_RECORD, VER_AVCC);
      repeat (3) add_word(KIND_RECORD, rand_byte());
      add_word(KIND_RECORD, rand_byte());   // length size in the low 2 bits
      nsets = $urandom_range(0, 3);
      add_word(KIND_RECORD, {3'($urandom_range(0, 7)), 5'(nsets)});
      repeat (nsets) add_set(broken);
      nsets = $urandom_range(0, 2);
      add_word(KIND_RECORD, 8'(nsets));
      repeat (nsets) add_set(broken);
      repeat ($urandom_range(0, 2)) add_word(KIND_RECORD, rand_byte());
    end
    close_burst();
  endtask

  // payload shaped by the current mode and length size
  task automatic make_payload();
    int          nals;
    int          k;
    int          body;
    logic [31:0] len;
    burst.delete();
    if (!avcc_on) begin
      repeat ($urandom_range(1, 6)) add_word(KIND_PAYLOAD, rand_byte());
    end else begin
      nals = $urandom_range(1, 3);
      repeat (nals) begin
        if ($urandom_range(0, 7) == 0) begin
          // wild length, body cut short
          len = $urandom;
          body = $urandom_range(0, 4);
        end else begin
          len = $urandom_range(0, 6);
          body = len;
        end
        for (k = int'(nal_len_bytes) - 1; k >= 0; k--) begin
          add_word(KIND_PAYLOAD, len[8*k +: 8]);
        end
        repeat (body) add_word(KIND_PAYLOAD, rand_byte());
      end
    end
    close_burst();
  endtask

  // offer one word after a random gap, wait for the handshake, then update the model
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_out);
    int gap;
    gap = pick_wait(calm_in);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.kind;
    s_tdata  <= w.data;
    s_tlast  <= w.last;
    do @(posedge clk); while (!s_tready);
    words_in++;
    convert_word(w, !typed);
    if (typed) annexb_due = {annexb_due, typed_out};
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, plus one long hold so the input backs up
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_wait(calm_out);
      if (hold_req && !hold_done) begin
        stall = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // compare every accepted output word with the oldest expected one
  always @(posedge clk) begin : out_check
    out_word_t got;
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser, m_tlast};
      words_out++;
      if (got.st != ST_DATA) begin
        ends_seen++;
        if (got.st != ST_END_OK) ends_flagged++;
      end
      if (annexb_due.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS)
          $display("%0t: word with nothing expected: byte %h status %0d last %b",
                   $time, got.val, got.st, got.run_end);
      end else begin
        want = annexb_due.pop_front();
        if (got !== want) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORTS)
            $display("%0t: mismatch, want %h/%0d/%b got %h/%0d/%b (byte/status/last)",
                     $time, want.val, want.st, want.run_end, got.val, got.st, got.run_end);
        end
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d words still expected",
                 $time, quiet, annexb_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_word_t  w;
    out_word_t t;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= KIND_RECORD;
    s_tlast  <= 1'b0;
    // model starts in pass-through with 4-byte lengths
    avcc_on       = 1'b0;
    nal_len_bytes = 3'd4;
    parse_ph      = PH_REC_FIRST;
    hdr_pos       = 3'd0;
    sets_left     = 8'd0;
    len_acc       = 32'd0;
    body_left     = 32'd0;
    len_seen      = 3'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      w = '{DIR_TAB[i].kind, DIR_TAB[i].data, DIR_TAB[i].last};
      t = '{DIR_TAB[i].t_val, DIR_TAB[i].t_st, 1'b1};
      send_word(w, DIR_TAB[i].typed, t);
    end

    // random buffers, mostly well-formed avcc records followed by payloads
    t = '{8'h00, ST_DATA, 1'b0};
    while (rand_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < (avcc_on ? 2 : 7)) begin
        make_record();
      end else begin
        make_payload();
      end
      foreach (burst[i]) begin
        send_word(burst[i], 1'b0, t);
        rand_sent++;
        if (rand_sent == HOLD_AT) hold_req = 1'b1;
      end
    end
    s_tvalid <= 1'b0;

    // drain, then give a stray word time to show up
    while (annexb_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d input words (%0d from the table), checked %0d output words",
             words_in, N_DIR, words_out);
    $display("saw %0d buffer ends, %0d of them flagged as errors, %0d mismatches",
             ends_seen, ends_flagged, bad_cnt);
    if (bad_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
